// ===== src/scanline_key_span_encoder_defines.svh =====
// assertion macros shared by the scanline key span encoder modules
// depends on nothing; taken in by `include where assertions are written
`ifndef SCANLINE_KEY_SPAN_ENCODER_DEFINES_SVH
`define SCANLINE_KEY_SPAN_ENCODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SKSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skse assertion failed");

// next-cycle implication, disabled during reset
`define SKSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skse assertion failed");

`endif

// ===== src/skse_pkg.sv =====
// shared types and constants of the scanline key span encoder
// depends on nothing; used by every module of the block
`default_nettype none

package skse_pkg;

   localparam int ROW_WIDTH  = 192;
   localparam int COL_W      = 8;
   localparam int COLOUR_W   = 24;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = 2;
   localparam int Q_CNT_W    = 3;

   localparam logic [COL_W-1:0]    LAST_COL       = COL_W'(ROW_WIDTH - 1);
   localparam logic [BYTE_W-1:0]   TERM_BYTE      = 8'hFF;
   localparam logic [COLOUR_W-1:0] KEY_RESET      = 24'h00FF00;
   localparam logic [BYTE_W-1:0]   LINE_RESET     = 8'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COLOUR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_MODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BYTES = 2'd2;

   localparam logic MODE_OUTER = 1'b0;
   localparam logic MODE_INNER = 1'b1;

   typedef struct packed {
      logic [COLOUR_W-1:0] key_colour;
      logic                span_mode;
      logic [BYTE_W-1:0]   line_bytes;
   } cfg_type;

   // one queued row record: optional left/jump pair, optional terminator
   typedef struct packed {
      logic              pair;
      logic [BYTE_W-1:0] half_l;
      logic [BYTE_W-1:0] len;
      logic              pad_one;
      logic              term;
   } span_rec_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEFT,
      PH_JUMP,
      PH_TERM
   } phase_type;

endpackage

`default_nettype wire

// ===== src/scanline_key_span_encoder.sv =====
// scanline key span encoder: pixel stream in, span bytes out
// Pixels enter on the req_ channel, 24-bit colour in req_tdata, row end on
// req_tlast and frame end on req_tuser. A pixel is taken each cycle while a
// four-entry record queue has room. Each closed row with a valid span
// gives two bytes on rsp_: the left column halved, then the jump byte; a
// frame end adds the byte 255 with rsp_tlast high.
// The accepted pixel that closes a row reaches its first byte through the
// record queue, the emitter's current-record register and the output
// register. The byte emitter sends one byte per cycle while rsp_tready
// is high; rows without a span put no record in the queue.
// When rsp_tready is low the output register holds its byte, the emitter
// pauses and the queue fills; once it holds four records req_tready drops.
// Reset (synchronous, active high) clears the row trackers, the queue and
// the output, and loads key colour 0x00FF00, outer mode and line length 64.
// Users write registers via csr_ with no transaction in flight; unenforced.
// depends on skse_pkg, skse_front, skse_queue and skse_back
`default_nettype none

module scanline_key_span_encoder (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [skse_pkg::COLOUR_W-1:0]        req_tdata,  // pixel_colour
   input  wire logic                                 req_tlast,  // row_end
   input  wire logic                                 req_tuser,  // frame_end
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [skse_pkg::BYTE_W-1:0]               rsp_tdata,  // out_byte
   output logic                                      rsp_tlast,  // is_terminator
   input  wire logic                                 csr_wen,
   input  wire logic [skse_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [skse_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   skse_pkg::cfg_type       cfg_ff;
   skse_pkg::span_rec_type  push_rec;
   skse_pkg::span_rec_type  pop_rec;
   logic                    push_valid;
   logic                    push_ready;
   logic                    pop;
   logic                    pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_colour <= skse_pkg::KEY_RESET;
         cfg_ff.span_mode  <= skse_pkg::MODE_OUTER;
         cfg_ff.line_bytes <= skse_pkg::LINE_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            skse_pkg::CSR_KEY_COLOUR: cfg_ff.key_colour <= csr_wdata;
            skse_pkg::CSR_SPAN_MODE:  cfg_ff.span_mode  <= csr_wdata[0];
            skse_pkg::CSR_LINE_BYTES: cfg_ff.line_bytes <= csr_wdata[skse_pkg::BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   skse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_tvalid),
      .in_pixel     (req_tdata),
      .in_row_end   (req_tlast),
      .in_frame_end (req_tuser),
      .push_ready   (push_ready),
      .in_ready     (req_tready),
      .push_valid   (push_valid),
      .push_rec     (push_rec)
   );

   skse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_rec    (pop_rec)
   );

   skse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (pop_valid),
      .q_rec     (pop_rec),
      .q_pop     (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_term  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== src/skse_front.sv =====
// front end: classifies pixels, tracks row bounds and builds row records
// depends on skse_pkg
`default_nettype none

module skse_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire skse_pkg::cfg_type                 cfg,
   input  wire logic                              in_valid,
   input  wire logic [skse_pkg::COLOUR_W-1:0]     in_pixel,
   input  wire logic                              in_row_end,
   input  wire logic                              in_frame_end,
   input  wire logic                              push_ready,
   output logic                                   in_ready,
   output logic                                   push_valid,
   output skse_pkg::span_rec_type                 push_rec
);

   logic [skse_pkg::COL_W-1:0] column_ff, column_in;
   logic                       seen_ff, seen_in;
   logic [skse_pkg::COL_W-1:0] first_op_ff, first_op_in;
   logic [skse_pkg::COL_W-1:0] last_op_ff, last_op_in;
   logic [skse_pkg::COL_W-1:0] run_end_ff, run_end_in;
   logic                       run_closed_ff, run_closed_in;
   logic [skse_pkg::COL_W-1:0] run_start_ff, run_start_in;
   logic                       keyed_left_ff, keyed_left_in;
   logic                       prev_key_ff, prev_key_in;

   logic                       accept;
   logic                       opaque;
   logic                       row_close;
   logic                       pair_ok;
   logic [skse_pkg::COL_W-1:0] left_col;
   logic [skse_pkg::COL_W-1:0] right_col;
   logic [skse_pkg::BYTE_W-1:0] half_l;
   logic [skse_pkg::BYTE_W-1:0] half_r;

   assign in_ready  = push_ready;
   assign accept    = in_valid && push_ready;
   assign opaque    = (in_pixel != cfg.key_colour);
   assign row_close = in_row_end || in_frame_end || (column_ff == skse_pkg::LAST_COL);

   // bound tracking including the current pixel
   always_comb begin
      seen_in       = seen_ff;
      first_op_in   = first_op_ff;
      last_op_in    = last_op_ff;
      run_end_in    = run_end_ff;
      run_closed_in = run_closed_ff;
      run_start_in  = run_start_ff;
      keyed_left_in = keyed_left_ff;
      prev_key_in   = prev_key_ff;
      if (opaque) begin
         if (!seen_ff) begin
            first_op_in = column_ff;
            seen_in     = 1'b1;
         end
         last_op_in = column_ff;
         if (prev_key_ff) begin
            run_start_in  = column_ff;
            keyed_left_in = (column_ff != '0);
         end
         prev_key_in = 1'b0;
      end else begin
         if (seen_ff && !run_closed_ff) begin
            run_closed_in = 1'b1;
            run_end_in    = column_ff - skse_pkg::COL_W'(1);
         end
         prev_key_in = 1'b1;
      end
   end

   // row close: pick bounds for the mode in force
   always_comb begin
      if (cfg.span_mode == skse_pkg::MODE_INNER) begin
         left_col  = run_end_in;
         right_col = run_start_in;
         pair_ok   = seen_in && run_closed_in && keyed_left_in && (left_col < right_col);
         half_r    = (right_col >> 1) + skse_pkg::BYTE_W'(right_col[0]);
      end else begin
         left_col  = first_op_in;
         right_col = last_op_in;
         pair_ok   = seen_in;
         half_r    = right_col >> 1;
      end
      half_l = left_col >> 1;
   end

   always_comb begin
      push_rec.pair    = row_close && pair_ok;
      push_rec.half_l  = half_l;
      push_rec.len     = half_r - half_l;
      push_rec.pad_one = (cfg.span_mode == skse_pkg::MODE_INNER);
      push_rec.term    = in_frame_end;
      push_valid       = accept && ((row_close && pair_ok) || in_frame_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         seen_ff       <= 1'b0;
         first_op_ff   <= '0;
         last_op_ff    <= '0;
         run_end_ff    <= '0;
         run_closed_ff <= 1'b0;
         run_start_ff  <= '0;
         keyed_left_ff <= 1'b0;
         prev_key_ff   <= 1'b1;
      end else if (accept) begin
         if (row_close) begin
            column_ff     <= '0;
            seen_ff       <= 1'b0;
            first_op_ff   <= '0;
            last_op_ff    <= '0;
            run_end_ff    <= '0;
            run_closed_ff <= 1'b0;
            run_start_ff  <= '0;
            keyed_left_ff <= 1'b0;
            prev_key_ff   <= 1'b1;
         end else begin
            column_ff     <= column_in;
            seen_ff       <= seen_in;
            first_op_ff   <= first_op_in;
            last_op_ff    <= last_op_in;
            run_end_ff    <= run_end_in;
            run_closed_ff <= run_closed_in;
            run_start_ff  <= run_start_in;
            keyed_left_ff <= keyed_left_in;
            prev_key_ff   <= prev_key_in;
         end
      end
   end

   assign column_in = column_ff + skse_pkg::COL_W'(1);

endmodule

`default_nettype wire

// ===== src/skse_queue.sv =====
// short record queue between front end and byte emitter
// depends on skse_pkg and the assertion macro header
`default_nettype none
`include "scanline_key_span_encoder_defines.svh"

module skse_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   input  wire skse_pkg::span_rec_type   push_rec,
   output logic                          push_ready,
   input  wire logic                     pop,
   output logic                          pop_valid,
   output skse_pkg::span_rec_type        pop_rec
);

   skse_pkg::span_rec_type               entry_ff [skse_pkg::Q_DEPTH];
   logic [skse_pkg::Q_PTR_W-1:0]         wptr_ff, wptr_in;
   logic [skse_pkg::Q_PTR_W-1:0]         rptr_ff, rptr_in;
   logic [skse_pkg::Q_CNT_W-1:0]         count_ff, count_in;
   logic                                 do_push;
   logic                                 do_pop;

   assign push_ready = (count_ff != skse_pkg::Q_CNT_W'(skse_pkg::Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_rec    = entry_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + skse_pkg::Q_PTR_W'(1) : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + skse_pkg::Q_PTR_W'(1) : rptr_ff;
      count_in = count_ff + skse_pkg::Q_CNT_W'(do_push) - skse_pkg::Q_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_rec;
      end
   end

   `SKSE_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
      count_ff <= skse_pkg::Q_CNT_W'(skse_pkg::Q_DEPTH))

endmodule

`default_nettype wire

// ===== src/skse_back.sv =====
// back end: turns queued row records into bytes, one per unstalled cycle
// depends on skse_pkg and the assertion macro header
`default_nettype none
`include "scanline_key_span_encoder_defines.svh"

module skse_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire skse_pkg::cfg_type               cfg,
   input  wire logic                            q_valid,
   input  wire skse_pkg::span_rec_type          q_rec,
   output logic                                 q_pop,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output logic [skse_pkg::BYTE_W-1:0]          out_byte,
   output logic                                 out_term
);

   skse_pkg::phase_type                 phase_ff, phase_in;
   skse_pkg::span_rec_type              cur_ff, cur_in;
   logic                                out_valid_ff;
   logic [skse_pkg::BYTE_W-1:0]         out_byte_ff;
   logic                                out_term_ff;

   logic                                out_free;
   logic                                emit;
   logic                                done;
   logic [skse_pkg::BYTE_W-1:0]         emit_byte;
   logic                                emit_term;
   logic [skse_pkg::BYTE_W-1:0]         pad;
   logic [skse_pkg::BYTE_W-1:0]         diff;
   logic [skse_pkg::BYTE_W-1:0]         jump;

   assign out_free = !out_valid_ff || out_ready;
   assign pad      = cur_ff.pad_one ? skse_pkg::BYTE_W'(1) : skse_pkg::BYTE_W'(2);
   assign diff     = cfg.line_bytes - cur_ff.len - pad;
   assign jump     = {diff[skse_pkg::BYTE_W-2:0], 1'b0};

   // outputs of the byte sequencer
   always_comb begin
      emit      = 1'b0;
      done      = 1'b0;
      emit_byte = '0;
      emit_term = 1'b0;
      unique case (phase_ff)
         skse_pkg::PH_IDLE: begin
            done = 1'b1;
         end
         skse_pkg::PH_LEFT: begin
            emit      = out_free;
            emit_byte = cur_ff.half_l;
         end
         skse_pkg::PH_JUMP: begin
            emit      = out_free;
            emit_byte = jump;
            done      = out_free && !cur_ff.term;
         end
         skse_pkg::PH_TERM: begin
            emit      = out_free;
            emit_byte = skse_pkg::TERM_BYTE;
            emit_term = 1'b1;
            done      = out_free;
         end
         default: begin
            done = 1'b1;
         end
      endcase
      q_pop = done && q_valid;
   end

   // next state of the byte sequencer
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         skse_pkg::PH_LEFT: begin
            if (out_free) begin
               phase_in = skse_pkg::PH_JUMP;
            end
         end
         skse_pkg::PH_JUMP: begin
            if (out_free && cur_ff.term) begin
               phase_in = skse_pkg::PH_TERM;
            end
         end
         default: begin
         end
      endcase
      if (done) begin
         if (q_valid) begin
            phase_in = q_rec.pair ? skse_pkg::PH_LEFT : skse_pkg::PH_TERM;
         end else begin
            phase_in = skse_pkg::PH_IDLE;
         end
      end
   end

   assign cur_in = q_pop ? q_rec : cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= skse_pkg::PH_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         out_byte_ff <= emit_byte;
         out_term_ff <= emit_term;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_term  = out_term_ff;

   `SKSE_ASSERT_IMPL(a_left_needs_pair, clock, reset,
      phase_ff == skse_pkg::PH_LEFT, cur_ff.pair)
   `SKSE_ASSERT_IMPL(a_term_byte, clock, reset,
      out_valid_ff && out_term_ff, out_byte_ff == skse_pkg::TERM_BYTE)
   `SKSE_ASSERT_IMPL(a_pop_only_when_free, clock, reset,
      q_pop && (phase_ff != skse_pkg::PH_IDLE), out_free)

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench for scanline_key_span_encoder: random pixel rows over several register settings
// a scoreboard class predicts the span bytes; depends on skse_pkg and the encoder RTL
`default_nettype none

module tb;
   import skse_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              term;
   } span_byte_type;

   class span_scoreboard;
      logic [COLOUR_W-1:0] key;
      logic                mode;
      logic [BYTE_W-1:0]   line_len;
      logic [COL_W-1:0]    col;
      logic [COL_W-1:0]    first_col;
      logic [COL_W-1:0]    last_col;
      logic [COL_W-1:0]    first_end;
      logic [COL_W-1:0]    run_start;
      bit                  seen;
      bit                  first_closed;
      bit                  run_keyed;
      bit                  prev_key;
      span_byte_type       expected_bytes[$];
      int                  errors;
      int                  pixels;
      int                  rows;
      int                  frames;
      int                  bytes_checked;

      function new();
         key = KEY_RESET;
         mode = MODE_OUTER;
         line_len = LINE_RESET;
         clear_row();
      endfunction

      function void report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endfunction

      function void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_KEY_COLOUR: key = val;
            CSR_SPAN_MODE: mode = val[0];
            CSR_LINE_BYTES: line_len = val[BYTE_W-1:0];
            default: ;
         endcase
      endfunction

      function void clear_row();
         col = '0;
         seen = 0;
         first_col = '0;
         last_col = '0;
         first_end = '0;
         first_closed = 0;
         run_start = '0;
         run_keyed = 0;
         prev_key = 1;
      endfunction

      // left byte then jump byte, or nothing when the row has no usable pair
      function void emit_span();
         logic [BYTE_W-1:0] lft, rgt, half_l, half_r, len, pad;
         span_byte_type     b;
         bit                ok;
         if (mode == MODE_INNER) begin
            ok = seen && first_closed && run_keyed && (first_end < run_start);
            lft = first_end;
            rgt = run_start;
            half_r = (rgt >> 1) + {7'd0, rgt[0]};
            pad = 8'd1;
         end else begin
            ok = seen;
            lft = first_col;
            rgt = last_col;
            half_r = rgt >> 1;
            pad = 8'd2;
         end
         if (!ok) return;
         half_l = lft >> 1;
         len = half_r - half_l;
         b.value = half_l;
         b.term = 1'b0;
         expected_bytes.push_back(b);
         b.value = (line_len - len - pad) << 1;
         expected_bytes.push_back(b);
      endfunction

      function void note_pixel(logic [COLOUR_W-1:0] colour, logic row_end, logic frame_end);
         span_byte_type b;
         pixels++;
         if (colour != key) begin
            if (!seen) begin
               first_col = col;
               seen = 1;
            end
            last_col = col;
            if (prev_key) begin
               run_start = col;
               run_keyed = (col != 0);
            end
            prev_key = 0;
         end else begin
            if (seen && !first_closed) begin
               first_closed = 1;
               first_end = col - 8'd1;
            end
            prev_key = 1;
         end
         // rows also close on their own at the last column
         if (row_end || frame_end || int'(col) + 1 >= ROW_WIDTH) begin
            rows++;
            emit_span();
            clear_row();
         end else begin
            col = col + 8'd1;
         end
         if (frame_end) begin
            frames++;
            b.value = TERM_BYTE;
            b.term = 1'b1;
            expected_bytes.push_back(b);
         end
      endfunction

      function void check_byte(logic [BYTE_W-1:0] value, logic term);
         span_byte_type e;
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            report($sformatf("byte %02h (term %0b) with none expected", value, term));
         end else begin
            e = expected_bytes.pop_front();
            if (value !== e.value)
               report($sformatf("byte %02h, expected %02h", value, e.value));
            if (term !== e.term)
               report($sformatf("terminator flag %0b, expected %0b on byte %02h",
                                term, e.term, e.value));
         end
      endfunction

      function void flush_leftovers();
         span_byte_type e;
         while (expected_bytes.size() != 0) begin
            e = expected_bytes.pop_front();
            report($sformatf("expected byte %02h (term %0b) never arrived", e.value, e.term));
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [COLOUR_W-1:0]   req_tdata;
   logic                  req_tlast;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [BYTE_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   span_scoreboard sb = new();
   bit send_rush;
   int settings;

   scanline_key_span_encoder DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap(bit rush);
      return rush ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic logic [COLOUR_W-1:0] opaque_colour();
      logic [COLOUR_W-1:0] c;
      // half the time one bit away from the key
      if ($urandom_range(0, 1) == 0)
         c = sb.key ^ (24'd1 << $urandom_range(0, 23));
      else
         c = COLOUR_W'($urandom_range(0, 24'hFFFFFF));
      if (c == sb.key)
         c = c ^ 24'd1;
      return c;
   endfunction

   task automatic send_pixel(logic [COLOUR_W-1:0] colour, logic row_end, logic frame_end);
      int gap;
      gap = draw_gap(send_rush);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= colour;
      req_tlast <= row_end;
      req_tuser <= frame_end;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_pixel(colour, row_end, frame_end);
   endtask

   // k is a key pixel, anything else an opaque one
   task automatic send_pattern(string pattern, logic row_end, logic frame_end);
      int last;
      last = pattern.len() - 1;
      for (int i = 0; i <= last; i++)
         send_pixel((pattern[i] == "k") ? sb.key : opaque_colour(),
                    (i == last) && row_end, (i == last) && frame_end);
   endtask

   // mostly alternating key and opaque runs, some rows of scattered pixels
   task automatic send_row(int len, logic row_end, logic frame_end);
      bit                  scattered;
      bit                  opq;
      int                  run_left;
      logic [COLOUR_W-1:0] c;
      send_rush = ($urandom_range(0, 3) == 0);
      scattered = ($urandom_range(0, 3) == 0);
      opq = 1'($urandom_range(0, 1));
      run_left = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
         if (scattered) begin
            c = ($urandom_range(0, 2) == 0) ? sb.key : opaque_colour();
         end else begin
            if (run_left == 0) begin
               opq = !opq;
               run_left = $urandom_range(1, 5);
            end
            run_left--;
            c = opq ? opaque_colour() : sb.key;
         end
         send_pixel(c, (i == len - 1) && row_end, (i == len - 1) && frame_end);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.apply_csr(idx, val);
   endtask

   task automatic configure(logic [COLOUR_W-1:0] key, logic mode, logic [BYTE_W-1:0] lb);
      wait_idle();
      write_reg(CSR_KEY_COLOUR, key);
      write_reg(CSR_SPAN_MODE, {23'd0, mode});
      write_reg(CSR_LINE_BYTES, {16'd0, lb});
      csr_wen <= 1'b0;
      settings++;
   endtask

   task automatic run_phase(logic [COLOUR_W-1:0] key, logic mode, logic [BYTE_W-1:0] lb,
                            bit with_long);
      int start_pixels;
      int len;
      configure(key, mode, lb);
      if (with_long) begin
         // one row that runs past the last column before its row end
         send_row(ROW_WIDTH + 8, 1'b1, 1'b0);
      end
      start_pixels = sb.pixels;
      while (sb.pixels - start_pixels < 20) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
         if ($urandom_range(0, 9) == 0)
            send_row(len, 1'($urandom_range(0, 1)), 1'b1);
         else
            send_row(len, 1'b1, 1'b0);
         if ($urandom_range(0, 7) == 0)
            wait_idle();
      end
      send_row($urandom_range(1, 12), 1'($urandom_range(0, 1)), 1'b1);
   endtask

   // result side: random stall before each transaction, with runs of no stall
   initial begin : receiver
      int n;
      bit rush;
      rush = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0)
            rush = !rush;
         n = draw_gap(rush);
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_byte(rsp_tdata, rsp_tlast);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAIL scanline_key_span_encoder");
      $finish;
   end

   initial begin
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      req_tuser <= 1'b0;
      csr_wen <= 1'b0;
      csr_index <= CSR_KEY_COLOUR;
      csr_wdata <= '0;
      send_rush = 0;
      settings = 1;
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // outer bounds with the reset settings
      send_pattern("kkoook", 1'b1, 1'b0);
      send_pattern("kkk", 1'b1, 1'b0);
      // extreme colours, frame end closing a row without row end
      send_pixel(24'hFFFFFF, 1'b0, 1'b0);
      send_pixel(24'h000000, 1'b0, 1'b1);

      // inner bounds: first run at column 0, a row whose runs overlap, an unclosed run
      configure(24'hFFFFFF, MODE_INNER, 8'd255);
      send_pattern("okookko", 1'b1, 1'b0);
      send_pattern("kook", 1'b1, 1'b0);
      send_pattern("ooo", 1'b1, 1'b1);

      run_phase(24'h000000, MODE_OUTER, 8'd0, 1'b1);
      run_phase(COLOUR_W'($urandom_range(0, 24'hFFFFFF)), MODE_INNER, 8'd255, 1'b0);
      run_phase(COLOUR_W'($urandom_range(0, 24'hFFFFFF)), MODE_OUTER,
                BYTE_W'($urandom_range(0, 255)), 1'b0);
      run_phase(COLOUR_W'($urandom_range(0, 24'hFFFFFF)), MODE_INNER, 8'd0, 1'b0);
      run_phase(24'hFFFFFF, MODE_OUTER, 8'd255, 1'b0);
      run_phase(COLOUR_W'($urandom_range(0, 24'hFFFFFF)), MODE_INNER,
                BYTE_W'($urandom_range(0, 255)), 1'b0);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.flush_leftovers();
      $display("run covered %0d pixels, %0d rows, %0d frames under %0d register settings",
               sb.pixels, sb.rows, sb.frames, settings);
      $display("%0d span bytes checked, %0d mismatches", sb.bytes_checked, sb.errors);
      if (sb.errors == 0)
         $display("PASS scanline_key_span_encoder");
      else
         $display("FAIL scanline_key_span_encoder");
      $finish;
   end

endmodule

`default_nettype wire

// ===== scanline_key_span_encoder.f =====
+incdir+src
src/skse_pkg.sv
src/skse_front.sv
src/skse_queue.sv
src/skse_back.sv
src/scanline_key_span_encoder.sv
test/tb.sv
